[src/tdp_pkg.sv]
package tdp_pkg;

    localparam int TDP_NUM_WIDTH = 16;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic next_div;
    } t_dp_cmd;

    typedef struct packed {
        logic lt_two;
        logic sq_gt_num;
        logic div_last;
        logic rem_zero;
    } t_dp_status;

endpackage

[src/tdp_cand_if.sv]
interface tdp_cand_if #(
    parameter int NUM_WIDTH = 16
);
    logic                 valid;
    logic                 ready;
    logic [NUM_WIDTH-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

[src/tdp_res_if.sv]
interface tdp_res_if;
    logic valid;
    logic ready;
    logic is_prime;

    modport source (output valid, output is_prime, input ready);
    modport sink   (input valid, input is_prime, output ready);
endinterface

[src/trial_division_prime_test_unit.sv]
// Trial-division primality test.
// i_cand (sink) takes one unsigned candidate per item; o_res (source) returns
// one is_prime bit per item, 1 for a prime, in the order the items came in.
// Both channels move an item on a rising edge with valid and ready high.
// Zero and one give 0; two and three give 1 without any trial.
// Work: a load step, then per divisor d = 2, 3, ... while d*d <= n a
// check step, NUM_WIDTH restoring-division steps and a test step, and a
// final step to the output register; there are at most sqrt(n) - 1 trial
// divisors. The shared one-bit-per-cycle remainder unit serves every
// divisor in turn; one item is in work at a time.
// The output register holds a finished result while the receiver stalls;
// the next item is accepted once that result is parked there, and work
// waits in its final cycle only when the register is still full.
// Synchronous active-low reset empties the output and returns to idle.
module trial_division_prime_test_unit
    import tdp_pkg::*;
#(
    parameter int NUM_WIDTH = TDP_NUM_WIDTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    tdp_cand_if.sink   i_cand,
    tdp_res_if.source  o_res
);

    t_dp_cmd    cmd;
    t_dp_status status;

    tdp_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cand.valid),
        .o_in_ready  (i_cand.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_out_prime (o_res.is_prime),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    tdp_datapath #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_candidate (i_cand.candidate),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

[src/tdp_datapath.sv]
module tdp_datapath
    import tdp_pkg::*;
#(
    parameter int NUM_WIDTH = TDP_NUM_WIDTH
) (
    input  logic                 i_clk,
    input  logic [NUM_WIDTH-1:0] i_candidate,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status
);

    localparam int SQW  = NUM_WIDTH + 2;
    localparam int CNTW = $clog2(NUM_WIDTH);
    localparam logic [CNTW-1:0] LAST_STEP = CNTW'(NUM_WIDTH - 1);

    logic [NUM_WIDTH-1:0] r_num;
    logic [NUM_WIDTH-1:0] r_div;
    logic [SQW-1:0]       r_sq;
    logic [NUM_WIDTH-1:0] r_shift;
    logic [NUM_WIDTH-1:0] r_rem;
    logic [CNTW-1:0]      r_cnt;

    logic [NUM_WIDTH:0]   rem_sh;
    logic [NUM_WIDTH:0]   rem_sub;
    logic                 rem_ge;
    logic [NUM_WIDTH-1:0] n_rem;

    assign rem_sh  = {r_rem, r_shift[NUM_WIDTH-1]};
    assign rem_ge  = (rem_sh >= {1'b0, r_div});
    assign rem_sub = rem_sh - {1'b0, r_div};
    assign n_rem   = rem_ge ? rem_sub[NUM_WIDTH-1:0] : rem_sh[NUM_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num <= i_candidate;
            r_div <= NUM_WIDTH'(2);
            r_sq  <= SQW'(4);
        end else if (i_cmd.next_div) begin
            r_div <= r_div + NUM_WIDTH'(1);
            r_sq  <= r_sq + SQW'({r_div, 1'b1});
        end

        if (i_cmd.div_start) begin
            r_shift <= r_num;
            r_rem   <= '0;
            r_cnt   <= LAST_STEP;
        end else if (i_cmd.div_step) begin
            r_shift <= {r_shift[NUM_WIDTH-2:0], 1'b0};
            r_rem   <= n_rem;
            r_cnt   <= r_cnt - CNTW'(1);
        end
    end

    assign o_status.lt_two    = (r_num < NUM_WIDTH'(2));
    assign o_status.sq_gt_num = (r_sq > SQW'(r_num));
    assign o_status.div_last  = (r_cnt == '0);
    assign o_status.rem_zero  = (r_rem == '0);

endmodule

[src/tdp_controller.sv]
module tdp_controller
    import tdp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_out_prime,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_TEST   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_res;
    logic       n_res;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       r_out_prime;
    logic       n_out_prime;

    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_prime = r_out_prime;
        o_cmd       = '0;
        o_in_ready  = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_status.lt_two) begin
                    n_res   = 1'b0;
                    n_state = ST_FINISH;
                end else if (i_status.sq_gt_num) begin
                    n_res   = 1'b1;
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_TEST;
                end
            end
            ST_TEST: begin
                if (i_status.rem_zero) begin
                    n_res   = 1'b0;
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.next_div = 1'b1;
                    n_state        = ST_CHECK;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_prime = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_res       <= n_res;
        r_out_prime <= n_out_prime;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_prime = r_out_prime;

endmodule

[sim/trial_division_prime_test_unit_tb.sv]
`timescale 1ns / 1ps

module trial_division_prime_test_unit_tb
    import tdp_pkg::*;
;

    localparam int W            = TDP_NUM_WIDTH;
    localparam int NUM_ROWS     = 20;
    localparam int RANDOM_ITEMS = 80;
    localparam int CALM_ITEMS   = 15;
    localparam int LONG_HOLD    = 12000;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 3_000_000;

    typedef struct packed {
        logic [W-1:0] cand;
        logic         typed;
        logic         want;
    } t_row;

    typedef struct packed {
        logic [W-1:0] cand;
        logic         want;
    } t_expect;

    localparam t_row ROWS [0:NUM_ROWS-1] = '{
        '{16'd0,     1'b1, 1'b0},
        '{16'd1,     1'b1, 1'b0},
        '{16'd2,     1'b1, 1'b1},
        '{16'd3,     1'b1, 1'b1},
        '{16'd4,     1'b1, 1'b0},
        '{16'd5,     1'b0, 1'b0},
        '{16'd7,     1'b0, 1'b0},
        '{16'd9,     1'b0, 1'b0},
        '{16'd11,    1'b0, 1'b0},
        '{16'd25,    1'b0, 1'b0},
        '{16'd49,    1'b0, 1'b0},
        '{16'd169,   1'b0, 1'b0},
        '{16'd63001, 1'b0, 1'b0},
        '{16'd65025, 1'b0, 1'b0},
        '{16'd65521, 1'b0, 1'b0},
        '{16'd65535, 1'b0, 1'b0},
        '{16'd65534, 1'b1, 1'b0},
        '{16'd32768, 1'b1, 1'b0},
        '{16'd43690, 1'b1, 1'b0},
        '{16'd21845, 1'b0, 1'b0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    tdp_cand_if #(.NUM_WIDTH(W)) cand_ch ();
    tdp_res_if                   res_ch ();

    trial_division_prime_test_unit #(
        .NUM_WIDTH(W)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cand  (cand_ch),
        .o_res   (res_ch)
    );

    t_expect     expected_flags [$];
    t_expect     oldest_flag;
    int          errors      = 0;
    int          checked     = 0;
    int          sent_count  = 0;
    int          prime_count = 0;
    int          hold_left   = 0;
    int          pace_count  = 0;
    int unsigned cycle_count = 0;
    bit          long_done   = 1'b0;
    bit          calm        = 1'b0;
    bit          tx_pace     = 1'b1;
    bit          rx_pace     = 1'b1;

    function automatic logic prime_flag(input logic [W-1:0] n);
        int unsigned v;
        int unsigned d;
        v = 32'(n);
        if (v < 2) return 1'b0;
        for (d = 2; d * d <= v; d++) begin
            if (v % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic send_candidate(input logic [W-1:0] value, input logic typed,
                                  input logic want);
        int      gap;
        t_expect e;
        @(negedge i_clk);
        if (!calm && tx_pace && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            cand_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cand_ch.valid     = 1'b1;
        cand_ch.candidate = value;
        @(posedge i_clk);
        while (!cand_ch.ready) @(posedge i_clk);
        e.cand = value;
        e.want = typed ? want : prime_flag(value);
        expected_flags.push_back(e);
        sent_count++;
        if (e.want) prime_count++;
    endtask

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        pace_count++;
        if (pace_count % 40 == 0) begin
            tx_pace = 1'($urandom_range(0, 1));
            rx_pace = 1'($urandom_range(0, 1));
        end
    end

    // hold off once for a long stretch so the block backs up into its input
    always @(negedge i_clk) begin
        if (!long_done && sent_count >= NUM_ROWS) begin
            hold_left = LONG_HOLD;
            long_done = 1'b1;
        end
        if (hold_left > 0) begin
            res_ch.ready = 1'b0;
            hold_left--;
        end else if (!calm && rx_pace && $urandom_range(0, 3) == 0) begin
            hold_left    = $urandom_range(1, 7) - 1;
            res_ch.ready = 1'b0;
        end else begin
            res_ch.ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_flags.size() == 0) begin
                $error("unexpected item: is_prime=%0b", res_ch.is_prime);
                errors++;
            end else begin
                oldest_flag = expected_flags.pop_front();
                checked++;
                if (res_ch.is_prime !== oldest_flag.want) begin
                    $error("is_prime for candidate %0d: expected %0b, actual %0b",
                           oldest_flag.cand, oldest_flag.want, res_ch.is_prime);
                    errors++;
                end
            end
        end
    end

    initial begin
        logic [W-1:0] value;
        int unsigned  root;
        i_rst_n           = 1'b0;
        cand_ch.valid     = 1'b0;
        cand_ch.candidate = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < NUM_ROWS; i++) begin
            send_candidate(ROWS[i].cand, ROWS[i].typed, ROWS[i].want);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
            case ($urandom_range(0, 7))
                0, 1, 2: value = W'($urandom_range(0, 400));
                3, 4, 5: value = W'($urandom);
                6:       value = W'($urandom_range(60000, 65535));
                default: begin
                    root  = $urandom_range(2, 255);
                    value = W'(root * root);
                end
            endcase
            send_candidate(value, 1'b0, 1'b0);
        end

        @(negedge i_clk);
        cand_ch.valid = 1'b0;
        while (expected_flags.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d results for %0d candidates, %0d of them prime",
                 checked, sent_count, prime_count);
        $display("covered edge values, squares of primes and a long output stall");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
